// ----- hw/rtl/mrhr_pkg.sv -----
package mrhr_pkg;

  localparam int unsigned MAX_REGS    = 125;
  localparam int unsigned BANK_SIZE   = 128;
  localparam int unsigned BANK_AW     = $clog2(BANK_SIZE);
  localparam int unsigned MEM_AW      = BANK_AW + 1;
  localparam int unsigned MEM_DEPTH   = 2 * BANK_SIZE;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QAW         = $clog2(QDEPTH);
  localparam int unsigned QCW         = $clog2(QDEPTH + 1);
  localparam int unsigned BUILD_BYTES = 5;
  localparam int unsigned BCW         = $clog2(BUILD_BYTES);

  localparam logic [7:0] FUNCTION_CODE = 8'd3;
  localparam logic [7:0] EXC_FLAG      = 8'h80;
  localparam logic [7:0] POS_MAX       = 8'd255;

  typedef enum logic [1:0] {
    OP_BUILD = 2'd0,
    OP_BYTE  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_REQ    = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXCEPTION = 3'd1,
    ST_BAD_FUNC  = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_INVALID   = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_START_ADDRESS  = 1'b0,
    CFG_REGISTER_COUNT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [7:0]  exc;
    logic [15:0] value;
    logic [15:0] addr;
    logic [15:0] cnt;
  } cmd_t;

endpackage

// ----- hw/rtl/mrhr_front.sv -----
module mrhr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [1:0]         operation_i,
  input  logic [7:0]         pdu_byte_i,
  input  logic               end_of_pdu_i,
  input  logic [6:0]         read_index_i,
  input  logic [15:0]        start_address_i,
  input  logic [15:0]        register_count_i,
  input  logic [mrhr_pkg::QCW-1:0] q_count_i,
  output logic               q_push_o,
  output mrhr_pkg::cmd_t     q_data_o
);
  import mrhr_pkg::*;

  logic [7:0]  pos_q, pos_d;
  logic [7:0]  fb_q, fb_d;
  logic [7:0]  sb_q, sb_d;
  logic [7:0]  hb_q, hb_d;
  logic        cb_q, cb_d;
  logic        stg_vld_q, stg_vld_d;
  cmd_t        stg_q, stg_d;

  logic [15:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] wvld_q;
  logic [15:0] rd_q;
  logic        rd_vld_q;

  logic              accept;
  logic              wr_en;
  logic [MEM_AW-1:0] wr_addr;
  logic [15:0]       wr_data;
  logic              rd_en;
  logic [MEM_AW-1:0] rd_addr;

  logic [7:0]  p2;
  logic [7:0]  fb_eff, sb_eff;
  logic [8:0]  len;
  logic [16:0] addr_end;
  logic        build_bad;
  status_e     st;
  logic [7:0]  exc;
  logic        commit;

  assign full_o = ({1'b0, q_count_i} + QCW'(stg_vld_q)) >= (QCW+1)'(QDEPTH);
  assign accept = push_i && !full_o;

  assign p2       = pos_q - 8'd2;
  assign fb_eff   = (pos_q == 8'd0) ? pdu_byte_i : fb_q;
  assign sb_eff   = (pos_q == 8'd1) ? pdu_byte_i : sb_q;
  assign len      = {1'b0, pos_q} + 9'd1;
  assign addr_end = {1'b0, start_address_i} + {1'b0, register_count_i};
  assign build_bad = (register_count_i == 16'd0) || (register_count_i > 16'(MAX_REGS)) ||
                     (addr_end > 17'h10000);

  always_comb begin
    st     = ST_OK;
    exc    = 8'd0;
    commit = 1'b0;
    if (fb_eff == (FUNCTION_CODE | EXC_FLAG)) begin
      st  = ST_EXCEPTION;
      exc = (pos_q != 8'd0) ? sb_eff : 8'd0;
    end else if (fb_eff != FUNCTION_CODE) begin
      st = ST_BAD_FUNC;
    end else if ((pos_q == 8'd0) || (register_count_i > 16'(MAX_REGS)) ||
                 ({9'd0, sb_eff} != {register_count_i, 1'b0}) ||
                 (len != ({1'b0, sb_eff} + 9'd2))) begin
      st = ST_BAD_LEN;
    end else begin
      commit = 1'b1;
    end
  end

  always_comb begin
    pos_d     = pos_q;
    fb_d      = fb_q;
    sb_d      = sb_q;
    hb_d      = hb_q;
    cb_d      = cb_q;
    stg_vld_d = 1'b0;
    stg_d     = '0;
    wr_en     = 1'b0;
    wr_addr   = {~cb_q, p2[BANK_AW:1]};
    wr_data   = {hb_q, pdu_byte_i};
    rd_en     = 1'b0;
    rd_addr   = {cb_q, read_index_i};
    if (accept) begin
      unique case (op_e'(operation_i))
        OP_BUILD: begin
          stg_vld_d = 1'b1;
          if (build_bad) begin
            stg_d.kind   = KIND_STATUS;
            stg_d.status = ST_INVALID;
          end else begin
            stg_d.kind = KIND_REQ;
            stg_d.addr = start_address_i;
            stg_d.cnt  = register_count_i;
          end
        end
        OP_BYTE: begin
          if (pos_q == 8'd0) begin
            fb_d = pdu_byte_i;
          end else if (pos_q == 8'd1) begin
            sb_d = pdu_byte_i;
          end else if (pos_q != POS_MAX) begin
            if (!p2[0]) begin
              hb_d = pdu_byte_i;
            end else begin
              wr_en = 1'b1;
            end
          end
          if (end_of_pdu_i) begin
            pos_d        = 8'd0;
            stg_vld_d    = 1'b1;
            stg_d.kind   = KIND_STATUS;
            stg_d.status = st;
            stg_d.exc    = exc;
            if (commit) begin
              cb_d = ~cb_q;
            end
          end else if (pos_q != POS_MAX) begin
            pos_d = pos_q + 8'd1;
          end
        end
        OP_READ: begin
          rd_en      = 1'b1;
          stg_vld_d  = 1'b1;
          stg_d.kind = KIND_READ;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      fb_q      <= '0;
      sb_q      <= '0;
      hb_q      <= '0;
      cb_q      <= 1'b0;
      stg_vld_q <= 1'b0;
      wvld_q    <= '0;
    end else begin
      pos_q     <= pos_d;
      fb_q      <= fb_d;
      sb_q      <= sb_d;
      hb_q      <= hb_d;
      cb_q      <= cb_d;
      stg_vld_q <= stg_vld_d;
      if (wr_en) begin
        wvld_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_vld_q <= wvld_q[rd_addr];
    end
  end

  always_comb begin
    q_push_o = stg_vld_q;
    q_data_o = stg_q;
    if (stg_q.kind == KIND_READ) begin
      q_data_o.value = rd_vld_q ? rd_q : 16'd0;
    end
  end

endmodule

// ----- hw/rtl/mrhr_fifo.sv -----
module mrhr_fifo (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  mrhr_pkg::cmd_t           data_i,
  input  logic                     pop_i,
  output mrhr_pkg::cmd_t           data_o,
  output logic                     empty_o,
  output logic [mrhr_pkg::QCW-1:0] count_o
);
  import mrhr_pkg::*;

  cmd_t           mem_q [QDEPTH];
  logic [QAW-1:0] wp_q, wp_d;
  logic [QAW-1:0] rp_q, rp_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic           do_pop;

  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rp_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wp_d  = push_i ? wp_q + QAW'(1) : wp_q;
    rp_d  = do_pop ? rp_q + QAW'(1) : rp_q;
    cnt_d = cnt_q + QCW'(push_i) - QCW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/mrhr_back.sv -----
module mrhr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mrhr_pkg::cmd_t cmd_i,
  input  logic           q_empty_i,
  output logic           q_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [1:0]     result_kind_o,
  output logic [7:0]     request_byte_o,
  output logic           last_of_run_o,
  output logic [2:0]     status_o,
  output logic [7:0]     exception_code_o,
  output logic [15:0]    register_value_o
);
  import mrhr_pkg::*;

  logic [BCW-1:0] bcnt_q, bcnt_d;
  logic           take;
  logic           last;

  assign empty_o = q_empty_i;
  assign take    = pop_i && !q_empty_i;
  assign last    = (cmd_i.kind != KIND_REQ) || (bcnt_q == BCW'(BUILD_BYTES - 1));
  assign q_pop_o = take && last;

  always_comb begin
    bcnt_d = bcnt_q;
    if (take) begin
      bcnt_d = last ? '0 : bcnt_q + BCW'(1);
    end
  end

  always_comb begin
    result_kind_o    = cmd_i.kind;
    request_byte_o   = 8'd0;
    last_of_run_o    = last;
    status_o         = 3'd0;
    exception_code_o = 8'd0;
    register_value_o = 16'd0;
    unique case (cmd_i.kind)
      KIND_REQ: begin
        case (bcnt_q)
          BCW'(0):  request_byte_o = FUNCTION_CODE;
          BCW'(1):  request_byte_o = cmd_i.addr[15:8];
          BCW'(2):  request_byte_o = cmd_i.addr[7:0];
          BCW'(3):  request_byte_o = cmd_i.cnt[15:8];
          default:  request_byte_o = cmd_i.cnt[7:0];
        endcase
      end
      KIND_STATUS: begin
        status_o         = cmd_i.status;
        exception_code_o = cmd_i.exc;
      end
      KIND_READ: begin
        register_value_o = cmd_i.value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q <= '0;
    end else begin
      bcnt_q <= bcnt_d;
    end
  end

endmodule

// ----- hw/rtl/modbus_read_holding_regs_pdu.sv -----
// Modbus function 3 PDU engine.
// Input queue side: present an item and raise push; it is taken on a clock
// edge with push high and full low. Operation 0 builds a request (five
// request bytes, or one invalid-request status), operation 1 feeds one
// response PDU byte (one status on the byte marked end_of_pdu, none
// otherwise), operation 2 reads one committed register.
// Result queue side: while empty is low the oldest result sits on the
// result ports; pop takes it. last_of_run marks the final result of an item.
// Configuration: cfg_valid_i/cfg_ready_o write start_address (index 0) or
// register_count (index 1); cfg_ready_o is always high. Write only when idle.
// A taken item is registered in the staging register, then written into the
// queue. Throughput: one item per cycle while full is low; a build item holds
// the result side for five pops. A four-entry queue plus one staging register
// decouple them: when the receiver stalls, full rises once four items wait.
// Reset clears the parse state, the committed-bank select, the per-entry
// written marks of the 256-word register store (unwritten entries read as
// zero), the queue and its staging register; no clearing pass is needed.
module modbus_read_holding_regs_pdu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  pdu_byte_i,
  input  logic        end_of_pdu_i,
  input  logic [6:0]  read_index_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  request_byte_o,
  output logic        last_of_run_o,
  output logic [2:0]  status_o,
  output logic [7:0]  exception_code_o,
  output logic [15:0] register_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import mrhr_pkg::*;

  logic [15:0]    start_address_q;
  logic [15:0]    register_count_q;
  logic [QCW-1:0] q_count;
  logic           q_push;
  cmd_t           q_wdata;
  cmd_t           q_rdata;
  logic           q_empty;
  logic           q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_address_q  <= 16'd0;
      register_count_q <= 16'd1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == {7'd0, CFG_START_ADDRESS}) begin
        start_address_q <= cfg_data_i;
      end
      if (cfg_index_i == {7'd0, CFG_REGISTER_COUNT}) begin
        register_count_q <= cfg_data_i;
      end
    end
  end

  mrhr_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_o           (full),
    .operation_i      (operation_i),
    .pdu_byte_i       (pdu_byte_i),
    .end_of_pdu_i     (end_of_pdu_i),
    .read_index_i     (read_index_i),
    .start_address_i  (start_address_q),
    .register_count_i (register_count_q),
    .q_count_i        (q_count),
    .q_push_o         (q_push),
    .q_data_o         (q_wdata)
  );

  mrhr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  mrhr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (q_rdata),
    .q_empty_i        (q_empty),
    .q_pop_o          (q_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .result_kind_o    (result_kind_o),
    .request_byte_o   (request_byte_o),
    .last_of_run_o    (last_of_run_o),
    .status_o         (status_o),
    .exception_code_o (exception_code_o),
    .register_value_o (register_value_o)
  );

endmodule
